/* rtl/core/btcs_pkg.sv */
// ----------------------------------------------------------------------------
// btcs_pkg
// Shared widths, codes and types of the best tree candidate search core.
// ----------------------------------------------------------------------------
`default_nettype none

package btcs_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int FREE_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int SPRIO_W = 9;
  localparam int KIND_W  = 2;

  localparam int DEF_TREE_FRAMES = 32768;
  localparam int DEF_BEST_SLOTS  = 4;
  localparam int DEF_MAX_TREES   = 4096;

  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_VISIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PERFECT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RANKED    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXHAUSTED = 2'd2;

  localparam logic [PRIO_W-1:0] PERFECT_PRIO = 8'hFF;

  typedef struct packed {
    logic [SPRIO_W-1:0] prio;
    logic [IDX_W-1:0]   tree;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/btcs_rem_unit.sv */
// ----------------------------------------------------------------------------
// btcs_rem_unit
// Iterative restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btcs_rem_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [btcs_pkg::IDX_W-1:0]   dividend,
  input  wire logic [btcs_pkg::CNT_W-1:0]   divisor,
  output logic                              done,
  output logic [btcs_pkg::IDX_W-1:0]        rem
);

  localparam int STEP_W = $clog2(btcs_pkg::IDX_W + 1);
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(btcs_pkg::IDX_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           cnt_r, cnt_nxt;
  logic [btcs_pkg::IDX_W-1:0]  dvd_r, dvd_nxt;
  logic [btcs_pkg::IDX_W-1:0]  rem_r, rem_nxt;
  logic [btcs_pkg::CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [btcs_pkg::CNT_W-1:0]  trial;
  logic [btcs_pkg::CNT_W-1:0]  diff;

  assign trial = {rem_r, dvd_r[btcs_pkg::IDX_W-1]};
  assign diff  = trial - dsr_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEPS;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[btcs_pkg::IDX_W-2:0], 1'b0};
      rem_nxt = (trial >= dsr_r) ? diff[btcs_pkg::IDX_W-1:0] : trial[btcs_pkg::IDX_W-1:0];
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* rtl/core/btcs_slot_cell.sv */
// ----------------------------------------------------------------------------
// btcs_slot_cell
// One entry of the ranked list: sorted insert from above, shift-out from below.
// ----------------------------------------------------------------------------
`default_nettype none

module btcs_slot_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire btcs_pkg::cell_ctrl_t          ctrl,
  input  wire logic [btcs_pkg::SPRIO_W-1:0]  new_prio,
  input  wire logic [btcs_pkg::IDX_W-1:0]    new_tree,
  input  wire btcs_pkg::slot_t               up_slot,
  input  wire logic                          up_wins,
  input  wire btcs_pkg::slot_t               down_slot,
  output btcs_pkg::slot_t                    slot,
  output logic                               wins
);

  btcs_pkg::slot_t slot_r, slot_nxt;

  assign wins = new_prio > slot_r.prio;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.clear) begin
      slot_nxt = '0;
    end else if (ctrl.shift) begin
      slot_nxt = down_slot;
    end else if (ctrl.insert && wins) begin
      if (up_wins) begin
        slot_nxt = up_slot;
      end else begin
        slot_nxt.prio = new_prio;
        slot_nxt.tree = new_tree;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

`default_nettype wire

/* rtl/core/best_tree_candidate_search_core.sv */
// ----------------------------------------------------------------------------
// best_tree_candidate_search_core
// Centre-out tree probe with filtering and a ranked top-K candidate list.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Word
// in_     | input     | in_valid/in_ready | op, start, threshold, probe data
// out_    | output    | out_valid/ready   | tree_index, kind, last
// cfg_    | input     | cfg_valid/ready   | tree_count
//
// Begin, op 3 and filtered visits leave the core idle and ready again. A kept
// visit runs two passes of the shared remainder unit (centre, then rounded-up
// half step, both mod the clamped tree count) in S_MODC and S_MODD, then the
// wrap fix in S_FIX and, with a perfect hit, S_OUT. Finish emits the list word
// by word, shifting it out of the cell row. Synchronous reset empties the list.
// A stalled output holds the word in the output register; the input side waits only inside an item.
// ----------------------------------------------------------------------------
`default_nettype none

module best_tree_candidate_search_core #(
  parameter int TREE_FRAMES = btcs_pkg::DEF_TREE_FRAMES,
  parameter int BEST_SLOTS  = btcs_pkg::DEF_BEST_SLOTS,
  parameter int MAX_TREES   = btcs_pkg::DEF_MAX_TREES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [btcs_pkg::OP_W-1:0]     in_op,
  input  wire logic [btcs_pkg::IDX_W-1:0]    in_start_req,
  input  wire logic [btcs_pkg::FREE_W-1:0]   in_min_free,
  input  wire logic [btcs_pkg::IDX_W-1:0]    in_step,
  input  wire logic                          in_reserved,
  input  wire logic [btcs_pkg::FREE_W-1:0]   in_free_frames,
  input  wire logic                          in_policy_match,
  input  wire logic [btcs_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [btcs_pkg::IDX_W-1:0]         out_tree_index,
  output logic [btcs_pkg::KIND_W-1:0]        out_kind,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [btcs_pkg::CNT_W-1:0]    cfg_tree_count
);

  localparam int IDX_W = btcs_pkg::IDX_W;
  localparam int CNT_W = btcs_pkg::CNT_W;

  localparam logic [16:0]      FRAMES_W  = 17'(TREE_FRAMES);
  localparam logic [16:0]      MAXT_W    = 17'(MAX_TREES);
  localparam logic [CNT_W-1:0] MAX_N     = MAXT_W[CNT_W-1:0];

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MODC = 3'd1;
  localparam logic [2:0] S_MODD = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               tc_r, tc_nxt;
  logic [IDX_W-1:0]               centre_r, centre_nxt;
  logic [btcs_pkg::FREE_W-1:0]    thr_r, thr_nxt;
  logic [IDX_W-1:0]               step_r, step_nxt;
  logic [btcs_pkg::PRIO_W-1:0]    prio_r, prio_nxt;
  logic [IDX_W-1:0]               cmod_r, cmod_nxt;
  logic [IDX_W-1:0]               dmod_r, dmod_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]               out_idx_r, out_idx_nxt;
  logic [btcs_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           in_acc;
  logic                           keep;
  logic                           out_open;
  logic [CNT_W-1:0]               n_eff;
  logic [IDX_W:0]                 d_wide;
  logic [IDX_W-1:0]               d_val;
  logic                           div_start;
  logic [IDX_W-1:0]               div_dvd;
  logic                           div_done;
  logic [IDX_W-1:0]               div_rem;
  logic [CNT_W-1:0]               sum_even, fix_even;
  logic [CNT_W:0]                 sum_odd, fix_odd;
  logic [IDX_W-1:0]               idx_calc;

  btcs_pkg::cell_ctrl_t           cell_ctrl;
  btcs_pkg::slot_t                slot [BEST_SLOTS];
  logic                           wins [BEST_SLOTS];
  logic                           next_empty;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_open  = !out_valid_r || out_ready;

  assign keep = !in_reserved && (in_free_frames >= thr_r)
             && ({1'b0, in_free_frames} != FRAMES_W) && in_policy_match;

  always_comb begin
    if (tc_r == '0) begin
      n_eff = CNT_W'(1);
    end else if ({4'b0, tc_r} > MAXT_W) begin
      n_eff = MAX_N;
    end else begin
      n_eff = tc_r;
    end
  end

  assign d_wide = ({1'b0, step_r} + {{IDX_W{1'b0}}, step_r[0]}) >> 1;
  assign d_val  = d_wide[IDX_W-1:0];

  assign sum_even = {1'b0, cmod_r} + {1'b0, dmod_r};
  assign fix_even = (sum_even >= n_eff) ? (sum_even - n_eff) : sum_even;
  assign sum_odd  = {2'b0, cmod_r} + {1'b0, n_eff} - {2'b0, dmod_r};
  assign fix_odd  = (sum_odd >= {1'b0, n_eff}) ? (sum_odd - {1'b0, n_eff}) : sum_odd;
  assign idx_calc = step_r[0] ? fix_odd[IDX_W-1:0] : fix_even[IDX_W-1:0];

  assign div_start = (in_acc && (in_op == btcs_pkg::OP_VISIT) && keep)
                  || ((state_r == S_MODC) && div_done);
  assign div_dvd   = (state_r == S_IDLE) ? centre_r : d_val;

  btcs_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  generate
    for (genvar k = 0; k < BEST_SLOTS; k++) begin : g_cell
      btcs_pkg::slot_t up_s;
      btcs_pkg::slot_t down_s;
      logic            up_w;
      if (k == 0) begin : g_head
        assign up_s = '0;
        assign up_w = 1'b0;
      end else begin : g_mid
        assign up_s = slot[k-1];
        assign up_w = wins[k-1];
      end
      if (k == BEST_SLOTS - 1) begin : g_tail
        assign down_s = '0;
      end else begin : g_body
        assign down_s = slot[k+1];
      end
      btcs_slot_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .new_prio  ({1'b0, prio_r} + btcs_pkg::SPRIO_W'(1)),
        .new_tree  (idx_calc),
        .up_slot   (up_s),
        .up_wins   (up_w),
        .down_slot (down_s),
        .slot      (slot[k]),
        .wins      (wins[k])
      );
    end
    if (BEST_SLOTS > 1) begin : g_next
      assign next_empty = (slot[1].prio == '0);
    end else begin : g_single
      assign next_empty = 1'b1;
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    tc_nxt        = tc_r;
    centre_nxt    = centre_r;
    thr_nxt       = thr_r;
    step_nxt      = step_r;
    prio_nxt      = prio_r;
    cmod_nxt      = cmod_r;
    dmod_nxt      = dmod_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    cell_ctrl     = '0;

    if (cfg_valid && cfg_ready) begin
      tc_nxt = cfg_tree_count;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            btcs_pkg::OP_BEGIN: begin
              centre_nxt      = in_start_req;
              thr_nxt         = in_min_free;
              cell_ctrl.clear = 1'b1;
            end
            btcs_pkg::OP_VISIT: begin
              step_nxt = in_step;
              prio_nxt = in_priority_req;
              if (keep) begin
                state_nxt = S_MODC;
              end
            end
            btcs_pkg::OP_FINISH: begin
              state_nxt = S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_MODC: begin
        if (div_done) begin
          cmod_nxt  = div_rem;
          state_nxt = S_MODD;
        end
      end
      S_MODD: begin
        if (div_done) begin
          dmod_nxt  = div_rem;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        idx_nxt = idx_calc;
        if (prio_r == btcs_pkg::PERFECT_PRIO) begin
          state_nxt = S_OUT;
        end else begin
          cell_ctrl.insert = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_open) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_kind_nxt  = btcs_pkg::KIND_PERFECT;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_open) begin
          out_valid_nxt = 1'b1;
          if (slot[0].prio == '0) begin
            out_idx_nxt  = '0;
            out_kind_nxt = btcs_pkg::KIND_EXHAUSTED;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_idx_nxt     = slot[0].tree;
            out_kind_nxt    = btcs_pkg::KIND_RANKED;
            out_last_nxt    = next_empty;
            cell_ctrl.shift = 1'b1;
            if (next_empty) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= CNT_W'(1);
      centre_r    <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      centre_r    <= centre_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r     <= step_nxt;
    prio_r     <= prio_nxt;
    cmod_r     <= cmod_nxt;
    dmod_r     <= dmod_nxt;
    idx_r      <= idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_tree_index = out_idx_r;
  assign out_kind       = out_kind_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire
